[sv/pkcomp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pkcomp_pkg;

    // envelope and gain formats
    localparam int ENV_W  = 24;
    localparam int GAIN_W = 17;
    localparam int COEF_W = 16;
    localparam int THR_W  = 17;
    localparam int MKUP_W = 26;

    // shared multiply-accumulate unit
    localparam int MUL_W = 27;
    localparam int ACC_W = 56;

    // gain divider: magnitude of numerator, quotient bits
    localparam int NUM_W = 43;
    localparam int QUO_W = 17;

    // configuration port
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 5;
    localparam int CFG_IXW = 3;

    localparam logic [CFG_IXW-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IXW-1:0] REG_RATIO_INV = 3'd1;
    localparam logic [CFG_IXW-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IXW-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IXW-1:0] REG_KNEE      = 3'd4;
    localparam logic [CFG_IXW-1:0] REG_MAKEUP    = 3'd5;

    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic signed [ENV_W-1:0] ENV_MAX = 24'sh7FFFFF;
    localparam logic signed [ENV_W-1:0] ENV_MIN = -24'sh800000;

    localparam logic signed [ACC_W-1:0] ACC_HALF = 56'sd32768;

    typedef logic signed [ACC_W-1:0] acc_t;

    function automatic logic signed [ENV_W-1:0] sat_env(input acc_t v);
        logic signed [ENV_W-1:0] r;
        if (v > acc_t'(ENV_MAX)) begin
            r = ENV_MAX;
        end else if (v < acc_t'(ENV_MIN)) begin
            r = ENV_MIN;
        end else begin
            r = ENV_W'(v);
        end
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] sat_gain(input acc_t v);
        logic [GAIN_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > acc_t'({1'b0, ONE_Q16})) begin
            r = ONE_Q16;
        end else begin
            r = GAIN_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/peak_compressor.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata: one sample per channel, ch0 lowest
// m_        out        m_tvalid/m_tready  m_tdata: one output per channel, ch0 lowest
// cfg       in         psel/penable       APB registers at 4*i, always ready
//
// One frame runs through a single multiply-accumulate unit and a radix-2 divider under
// a state sequencer; the gain divide runs only when the attack envelope is nonzero,
// has the same sign as the numerator and gives a quotient below two. s_tready is high
// only while idle; a finished frame waits in the output register, and the next one
// starts meanwhile but stalls in its last state until that beat is taken. Reset is
// synchronous, active low; clears both envelopes and smoothed gain, presets registers.
module peak_compressor
    import pkcomp_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // sample_ch0, sample_ch1, ... (SAMPLE_BITS each), zero pad
    input  wire  [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // out_ch0, out_ch1, ... (SAMPLE_BITS each), zero pad
    output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire  [CFG_AW-1:0]                        paddr,
    input  wire  [CFG_DW-1:0]                        pwdata,
    output logic [CFG_DW-1:0]                        prdata,
    output logic                                     pready
);

    localparam int TDATA_W = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(CHANNELS);
    localparam int EXT_W   = SUM_W + 17;
    localparam int Q_SH_L  = (SAMPLE_BITS <= 17) ? 17 - SAMPLE_BITS : 0;
    localparam int Q_SH_R  = (SAMPLE_BITS > 17) ? SAMPLE_BITS - 17 : 0;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int T_W     = SAMPLE_BITS + 1;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam acc_t SMP_HI = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam acc_t SMP_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SUM   = 5'd1;
    localparam logic [4:0] ST_ENV   = 5'd2;
    localparam logic [4:0] ST_REL1  = 5'd3;
    localparam logic [4:0] ST_REL2  = 5'd4;
    localparam logic [4:0] ST_REL3  = 5'd5;
    localparam logic [4:0] ST_ATT1  = 5'd6;
    localparam logic [4:0] ST_ATT2  = 5'd7;
    localparam logic [4:0] ST_ATT3  = 5'd8;
    localparam logic [4:0] ST_NUM   = 5'd9;
    localparam logic [4:0] ST_DIV0  = 5'd10;
    localparam logic [4:0] ST_DIV   = 5'd11;
    localparam logic [4:0] ST_KNEE1 = 5'd12;
    localparam logic [4:0] ST_KNEE2 = 5'd13;
    localparam logic [4:0] ST_KNEE3 = 5'd14;
    localparam logic [4:0] ST_OUT1  = 5'd15;
    localparam logic [4:0] ST_OUT2  = 5'd16;
    localparam logic [4:0] ST_OUT3  = 5'd17;
    localparam logic [4:0] ST_OUT4  = 5'd18;
    localparam logic [4:0] ST_FIN   = 5'd19;

    // configuration
    logic [THR_W-1:0]  thr_reg;
    logic [THR_W-1:0]  ratio_reg;
    logic [COEF_W-1:0] atk_reg;
    logic [COEF_W-1:0] rls_reg;
    logic [COEF_W-1:0] knee_reg;
    logic [MKUP_W-1:0] mkup_reg;

    logic                   cfg_wr;
    logic [CFG_IXW-1:0]     cfg_ix;

    // sequencer and datapath
    logic [4:0]                    st_reg, st_next;
    logic [CH_W-1:0]               ch_reg, ch_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    acc_t                          acc_reg, acc_next;
    logic signed [ENV_W-1:0]       env_reg, env_next;
    logic signed [ENV_W-1:0]       rel_reg, rel_next;
    logic signed [ENV_W-1:0]       att_reg, att_next;
    logic [GAIN_W-1:0]             gain_reg, gain_next;
    logic [GAIN_W-1:0]             sg_reg, sg_next;
    logic signed [T_W-1:0]         t_reg, t_next;
    logic [ENV_W-1:0]              rem_reg, rem_next;
    logic [QUO_W-1:0]              nlow_reg, nlow_next;
    logic [QUO_W-1:0]              quo_reg, quo_next;
    logic [4:0]                    dcnt_reg, dcnt_next;
    logic                          mval_reg, mval_next;
    logic [TDATA_W-1:0]            mdata_reg, mdata_next;

    logic signed [SAMPLE_BITS-1:0] samp_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] ych_reg  [CHANNELS];

    logic signed [MUL_W-1:0]       mul_x, mul_y;
    logic signed [2*MUL_W-1:0]     prod;
    acc_t                          acc_mac;
    acc_t                          acc_sh;
    logic signed [EXT_W-1:0]       sum_ext, q16;
    logic signed [ENV_W-1:0]       hold;
    logic signed [ENV_W+1:0]       att_diff;
    logic [ENV_W-1:0]              den_abs;
    logic [NUM_W-1:0]              num_abs;
    logic [ENV_W:0]                div_trial;
    logic                          div_bit;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic [GAIN_W-1:0]             c_rls, c_atk, c_knee;

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign pready   = 1'b1;

    // ---------------- configuration port ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_ix = paddr[CFG_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= ONE_Q16;
            ratio_reg <= ONE_Q16;
            atk_reg   <= '0;
            rls_reg   <= '0;
            knee_reg  <= '0;
            mkup_reg  <= MKUP_W'(ONE_Q16);
        end else if (cfg_wr) begin
            case (cfg_ix)
                REG_THRESHOLD: thr_reg   <= pwdata[THR_W-1:0];
                REG_RATIO_INV: ratio_reg <= pwdata[THR_W-1:0];
                REG_ATTACK:    atk_reg   <= pwdata[COEF_W-1:0];
                REG_RELEASE:   rls_reg   <= pwdata[COEF_W-1:0];
                REG_KNEE:      knee_reg  <= pwdata[COEF_W-1:0];
                REG_MAKEUP:    mkup_reg  <= pwdata[MKUP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_ix)
            REG_THRESHOLD: prdata = CFG_DW'(thr_reg);
            REG_RATIO_INV: prdata = CFG_DW'(ratio_reg);
            REG_ATTACK:    prdata = CFG_DW'(atk_reg);
            REG_RELEASE:   prdata = CFG_DW'(rls_reg);
            REG_KNEE:      prdata = CFG_DW'(knee_reg);
            REG_MAKEUP:    prdata = CFG_DW'(mkup_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- shared arithmetic ----------------
    assign c_rls  = ONE_Q16 - GAIN_W'(rls_reg);
    assign c_atk  = ONE_Q16 - GAIN_W'(atk_reg);
    assign c_knee = ONE_Q16 - GAIN_W'(knee_reg);

    assign hold     = (env_reg > rel_reg) ? env_reg : rel_reg;
    assign att_diff = (ENV_W+2)'(att_reg) - (ENV_W+2)'(signed'({1'b0, thr_reg}));

    always_comb begin
        case (st_reg)
            ST_REL1: begin
                mul_x = MUL_W'(signed'({1'b0, c_rls}));
                mul_y = MUL_W'(env_reg);
            end
            ST_REL2: begin
                mul_x = MUL_W'(signed'({1'b0, rls_reg}));
                mul_y = MUL_W'(hold);
            end
            ST_ATT1: begin
                mul_x = MUL_W'(signed'({1'b0, c_atk}));
                mul_y = MUL_W'(rel_reg);
            end
            ST_ATT2: begin
                mul_x = MUL_W'(signed'({1'b0, atk_reg}));
                mul_y = MUL_W'(att_reg);
            end
            ST_NUM: begin
                mul_x = MUL_W'(signed'({1'b0, ratio_reg}));
                mul_y = MUL_W'(att_diff);
            end
            ST_KNEE1: begin
                mul_x = MUL_W'(signed'({1'b0, c_knee}));
                mul_y = MUL_W'(signed'({1'b0, gain_reg}));
            end
            ST_KNEE2: begin
                mul_x = MUL_W'(signed'({1'b0, knee_reg}));
                mul_y = MUL_W'(signed'({1'b0, sg_reg}));
            end
            ST_OUT1: begin
                mul_x = MUL_W'(signed'({1'b0, sg_reg}));
                mul_y = MUL_W'(samp_reg[0]);
            end
            ST_OUT3: begin
                mul_x = MUL_W'(signed'({1'b0, mkup_reg}));
                mul_y = MUL_W'(t_reg);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod    = mul_x * mul_y;
    assign acc_mac = acc_reg + ACC_W'(prod);
    // acc carries the +0.5 LSB preload, so a floor shift rounds half up
    assign acc_sh  = acc_reg >>> 16;

    assign sum_ext = EXT_W'(sum_reg);
    assign q16     = (sum_ext <<< Q_SH_L) >>> Q_SH_R;

    assign den_abs = att_reg[ENV_W-1] ? ENV_W'(-att_reg) : ENV_W'(att_reg);
    assign num_abs = acc_reg[ACC_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);

    assign div_trial = {rem_reg, nlow_reg[QUO_W-1]};
    assign div_bit   = (div_trial >= {1'b0, den_abs});

    always_comb begin
        if (acc_sh > SMP_HI) begin
            y_sat = SAMPLE_BITS'(SMP_HI);
        end else if (acc_sh < SMP_LO) begin
            y_sat = SAMPLE_BITS'(SMP_LO);
        end else begin
            y_sat = SAMPLE_BITS'(acc_sh);
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        st_next    = st_reg;
        ch_next    = ch_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        env_next   = env_reg;
        rel_next   = rel_reg;
        att_next   = att_reg;
        gain_next  = gain_reg;
        sg_next    = sg_reg;
        t_next     = t_reg;
        rem_next   = rem_reg;
        nlow_next  = nlow_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        mval_next  = mval_reg && !m_tready;
        mdata_next = mdata_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sum_next = '0;
                    ch_next  = '0;
                    st_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                sum_next = sum_reg + SUM_W'(samp_reg[0]);
                if (ch_reg == CH_LAST) begin
                    ch_next = '0;
                    st_next = ST_ENV;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_ENV: begin
                env_next = sat_env(ACC_W'(q16));
                acc_next = ACC_HALF;
                st_next  = ST_REL1;
            end
            ST_REL1: begin
                acc_next = acc_mac;
                st_next  = ST_REL2;
            end
            ST_REL2: begin
                acc_next = acc_mac;
                st_next  = ST_REL3;
            end
            ST_REL3: begin
                rel_next = sat_env(acc_sh);
                acc_next = ACC_HALF;
                st_next  = ST_ATT1;
            end
            ST_ATT1: begin
                acc_next = acc_mac;
                st_next  = ST_ATT2;
            end
            ST_ATT2: begin
                acc_next = acc_mac;
                st_next  = ST_ATT3;
            end
            ST_ATT3: begin
                att_next = sat_env(acc_sh + acc_t'(1));
                acc_next = ACC_W'({thr_reg, 16'h0000});
                st_next  = ST_NUM;
            end
            ST_NUM: begin
                acc_next = acc_mac;
                st_next  = ST_DIV0;
            end
            ST_DIV0: begin
                // zero envelope or quotient of two or more: unity; opposite signs: zero
                if (att_reg == '0) begin
                    gain_next = ONE_Q16;
                    acc_next  = ACC_HALF;
                    st_next   = ST_KNEE1;
                end else if (acc_reg[ACC_W-1] != att_reg[ENV_W-1]) begin
                    gain_next = '0;
                    acc_next  = ACC_HALF;
                    st_next   = ST_KNEE1;
                end else if (num_abs[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den_abs)) begin
                    gain_next = ONE_Q16;
                    acc_next  = ACC_HALF;
                    st_next   = ST_KNEE1;
                end else begin
                    rem_next  = num_abs[QUO_W +: ENV_W];
                    nlow_next = num_abs[QUO_W-1:0];
                    quo_next  = '0;
                    dcnt_next = 5'(QUO_W - 1);
                    st_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_bit ? ENV_W'(div_trial - {1'b0, den_abs})
                                    : ENV_W'(div_trial);
                nlow_next = {nlow_reg[QUO_W-2:0], 1'b0};
                quo_next  = {quo_reg[QUO_W-2:0], div_bit};
                if (dcnt_reg == '0) begin
                    gain_next = (quo_next > ONE_Q16) ? ONE_Q16 : quo_next;
                    acc_next  = ACC_HALF;
                    st_next   = ST_KNEE1;
                end else begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            ST_KNEE1: begin
                acc_next = acc_mac;
                st_next  = ST_KNEE2;
            end
            ST_KNEE2: begin
                acc_next = acc_mac;
                st_next  = ST_KNEE3;
            end
            ST_KNEE3: begin
                sg_next  = sat_gain(acc_sh);
                acc_next = ACC_HALF;
                ch_next  = '0;
                st_next  = ST_OUT1;
            end
            ST_OUT1: begin
                acc_next = acc_mac;
                st_next  = ST_OUT2;
            end
            ST_OUT2: begin
                t_next   = T_W'(acc_sh);
                acc_next = ACC_HALF;
                st_next  = ST_OUT3;
            end
            ST_OUT3: begin
                acc_next = acc_mac;
                st_next  = ST_OUT4;
            end
            ST_OUT4: begin
                acc_next = ACC_HALF;
                if (ch_reg == CH_LAST) begin
                    ch_next = '0;
                    st_next = ST_FIN;
                end else begin
                    ch_next = ch_reg + 1'b1;
                    st_next = ST_OUT1;
                end
            end
            ST_FIN: begin
                if (!mval_reg || m_tready) begin
                    mdata_next = '0;
                    for (int j = 0; j < CHANNELS; j++) begin
                        mdata_next[j*SAMPLE_BITS +: SAMPLE_BITS] = ych_reg[j];
                    end
                    mval_next = 1'b1;
                    st_next   = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            ch_reg   <= '0;
            rel_reg  <= '0;
            att_reg  <= '0;
            sg_reg   <= '0;
            mval_reg <= 1'b0;
            dcnt_reg <= '0;
        end else begin
            st_reg   <= st_next;
            ch_reg   <= ch_next;
            rel_reg  <= rel_next;
            att_reg  <= att_next;
            sg_reg   <= sg_next;
            mval_reg <= mval_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        env_reg   <= env_next;
        gain_reg  <= gain_next;
        t_reg     <= t_next;
        rem_reg   <= rem_next;
        nlow_reg  <= nlow_next;
        quo_reg   <= quo_next;
        mdata_reg <= mdata_next;
    end

    // samples rotate through slot 0 once for the sum and once for the outputs
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (s_tvalid && s_tready) begin
                samp_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end else if (st_reg == ST_SUM || st_reg == ST_OUT4) begin
                samp_reg[i] <= samp_reg[(i + 1) % CHANNELS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_OUT4) begin
            for (int i = 0; i < CHANNELS - 1; i++) begin
                ych_reg[i] <= ych_reg[i + 1];
            end
            ych_reg[CHANNELS-1] <= y_sat;
        end
    end

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a frame is in work");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_KNEE1 |-> gain_reg <= ONE_Q16 && sg_reg <= ONE_Q16)
        else $error("gain above unity");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> rem_reg < den_abs)
        else $error("divider remainder not below divisor");

    a_fin_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_FIN && (!m_tvalid || m_tready) |=> m_tvalid && s_tready)
        else $error("finished frame not handed to output register");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pkcomp_pkg::*;

    localparam int NCH            = 2;
    localparam int SBITS          = 16;
    localparam int DW             = ((NCH*SBITS+7)/8)*8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASES         = 10;
    localparam int PHASE_FRAMES   = 110;

    // addresses past the register list, writes there must change nothing
    localparam logic [CFG_IXW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IXW-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [SBITS-1:0] sample_t;
    typedef struct packed {
        sample_t ch1;
        sample_t ch0;
    } frame_t;

    class pk_scoreboard;
        logic [THR_W-1:0]        thr;
        logic [THR_W-1:0]        ratio_inv;
        logic [COEF_W-1:0]       atk_c;
        logic [COEF_W-1:0]       rel_c;
        logic [COEF_W-1:0]       knee_c;
        logic [MKUP_W-1:0]       makeup;
        logic signed [ENV_W-1:0] rel_env;
        logic signed [ENV_W-1:0] atk_env;
        logic [GAIN_W-1:0]       gain_sm;
        frame_t                  expected_frames[$];
        int                      failures;
        int                      frames_checked;
        int                      zero_env_hits;
        int                      clipped_samples;

        function new();
            thr             = ONE_Q16;
            ratio_inv       = ONE_Q16;
            atk_c           = '0;
            rel_c           = '0;
            knee_c          = '0;
            makeup          = MKUP_W'(ONE_Q16);
            rel_env         = '0;
            atk_env         = '0;
            gain_sm         = '0;
            failures        = 0;
            frames_checked  = 0;
            zero_env_hits   = 0;
            clipped_samples = 0;
        endfunction

        function void report(string what, longint want, longint got);
            failures++;
            if (failures <= 10)
                $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void set_reg(logic [CFG_IXW-1:0] idx, logic [CFG_DW-1:0] v);
            case (idx)
                REG_THRESHOLD: thr = v[THR_W-1:0];
                REG_RATIO_INV: ratio_inv = v[THR_W-1:0];
                REG_ATTACK:    atk_c = v[COEF_W-1:0];
                REG_RELEASE:   rel_c = v[COEF_W-1:0];
                REG_KNEE:      knee_c = v[COEF_W-1:0];
                REG_MAKEUP:    makeup = v[MKUP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CFG_DW-1:0] reg_value(logic [CFG_IXW-1:0] idx);
            logic [CFG_DW-1:0] r;
            case (idx)
                REG_THRESHOLD: r = CFG_DW'(thr);
                REG_RATIO_INV: r = CFG_DW'(ratio_inv);
                REG_ATTACK:    r = CFG_DW'(atk_c);
                REG_RELEASE:   r = CFG_DW'(rel_c);
                REG_KNEE:      r = CFG_DW'(knee_c);
                REG_MAKEUP:    r = CFG_DW'(makeup);
                default:       r = '0;
            endcase
            return r;
        endfunction

        // round half up on a Q16 product; >>> on longint is a floor
        function longint rnd16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint pole(longint a, longint x, longint prev);
            return rnd16((65536 - a) * x + a * prev);
        endfunction

        function sample_t scale_sample(longint s, longint g);
            longint y;
            y = rnd16(rnd16(s * g) * longint'(makeup));
            if (y > 32767 || y < -32768)
                clipped_samples++;
            return sample_t'(clamp(y, -32768, 32767));
        endfunction

        function void note_frame(frame_t f);
            longint s0, s1, env, hold, rel, att, gain, num, sm;
            frame_t res;
            s0 = longint'(f.ch0);
            s1 = longint'(f.ch1);
            env = clamp((s0 + s1) * 2, ENV_MIN, ENV_MAX);
            hold = env > longint'(rel_env) ? env : longint'(rel_env);
            rel = clamp(pole(longint'(rel_c), env, hold), ENV_MIN, ENV_MAX);
            rel_env = rel[ENV_W-1:0];
            att = clamp(pole(longint'(atk_c), rel, longint'(atk_env)) + 1, ENV_MIN, ENV_MAX);
            atk_env = att[ENV_W-1:0];
            if (att == 0) begin
                gain = 65536;
                zero_env_hits++;
            end else begin
                num = longint'(thr) * 65536 + longint'(ratio_inv) * (att - longint'(thr));
                gain = clamp(num / att, 0, 65536);
            end
            sm = clamp(pole(longint'(knee_c), gain, longint'(gain_sm)), 0, 65536);
            gain_sm = sm[GAIN_W-1:0];
            res.ch0 = scale_sample(s0, sm);
            res.ch1 = scale_sample(s1, sm);
            expected_frames.push_back(res);
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            if (expected_frames.size() == 0) begin
                report("unexpected output beat", 0, longint'(got));
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            if (got.ch0 !== want.ch0)
                report($sformatf("out_ch0 of frame %0d", frames_checked), want.ch0, got.ch0);
            if (got.ch1 !== want.ch1)
                report($sformatf("out_ch1 of frame %0d", frames_checked), want.ch1, got.ch1);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DW-1:0]     s_tdata;   // sample_ch0, sample_ch1
    logic              m_tvalid;
    logic              m_tready;
    logic [DW-1:0]     m_tdata;   // out_ch0, out_ch1
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    pk_scoreboard sb = new();

    bit idle_on      = 1'b1;
    int rx_stall     = 0;
    int idle_cycles  = 0;
    int run_left     = 0;
    int dc           = 0;
    int noise        = 0;
    int settings_cnt = 0;

    peak_compressor #(
        .CHANNELS    (NCH),
        .SAMPLE_BITS (SBITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic sample_t sat16(int v);
        return sample_t'(v > 32767 ? 32767 : (v < -32768 ? -32768 : v));
    endfunction

    function automatic frame_t mk_frame(int c0, int c1);
        frame_t f;
        f.ch0 = sat16(c0);
        f.ch1 = sat16(c1);
        return f;
    endfunction

    // runs of correlated samples around a DC level so the envelopes settle
    function automatic frame_t next_frame();
        if (run_left == 0) begin
            run_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                dc = int'($urandom_range(0, 1024)) - 512;
            else
                dc = int'($urandom_range(0, 65535)) - 32768;
            noise = 1 << $urandom_range(0, 15);
        end
        run_left--;
        if ($urandom_range(0, 9) == 0)
            return frame_t'($urandom());
        return mk_frame(dc + int'($urandom_range(0, 2*noise)) - noise,
                        dc + int'($urandom_range(0, 2*noise)) - noise);
    endfunction

    function automatic logic [CFG_DW-1:0] rand_level();
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        return $urandom_range(0, 65536);
    endfunction

    function automatic logic [CFG_DW-1:0] rand_coef();
        if ($urandom_range(0, 1) == 0)
            return 65536 - (1 << $urandom_range(0, 12));
        return $urandom_range(0, 65535);
    endfunction

    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame(frame_t'(m_tdata));
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d frames outstanding",
                     idle_cycles, sb.expected_frames.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // all tasks start and end on a falling edge with nothing yet driven there
    task automatic apb_write(input logic [CFG_IXW-1:0] idx, input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IXW-1:0] idx, input logic [CFG_DW-1:0] val);
        apb_write(idx, val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== sb.reg_value(idx))
            sb.report($sformatf("readback of register %0d", idx), sb.reg_value(idx), prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_DW-1:0] t, input logic [CFG_DW-1:0] r,
                             input logic [CFG_DW-1:0] a, input logic [CFG_DW-1:0] rl,
                             input logic [CFG_DW-1:0] k, input logic [CFG_DW-1:0] m);
        program_reg(REG_THRESHOLD, t);
        program_reg(REG_RATIO_INV, r);
        program_reg(REG_ATTACK, a);
        program_reg(REG_RELEASE, rl);
        program_reg(REG_KNEE, k);
        program_reg(REG_MAKEUP, m);
        settings_cnt++;
    endtask

    task automatic send_frame(input frame_t f, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_frame(f);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        // change idle pattern off the falling edge the receiver runs on
        idle_on = ($urandom_range(0, 3) != 0);
        @(negedge aclk);
    endtask

    initial begin
        int phase;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: unity everything, full-scale threshold
        send_frame(mk_frame(0, 0), pick_gap());
        send_frame(mk_frame(32767, 32767), pick_gap());
        send_frame(mk_frame(-32768, -32768), pick_gap());
        send_frame(mk_frame(32767, -32768), pick_gap());
        send_frame(mk_frame(-32768, 32767), pick_gap());
        send_frame(mk_frame(1, -1), pick_gap());
        send_frame(mk_frame(-1, 0), pick_gap());
        drain();

        // writes past the register list must be dropped
        apb_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        apb_write(REG_SPARE_HI, 32'h0000_1234);

        // half-rate attack, instant release: a sum of -1 drives the attack envelope to zero
        configure(16384, 16384, 32768, 0, 0, 4*65536);
        send_frame(mk_frame(-1, 0), pick_gap());
        send_frame(mk_frame(-1, 0), pick_gap());
        send_frame(mk_frame(-1, 0), pick_gap());
        send_frame(mk_frame(-20000, -20000), pick_gap());
        send_frame(mk_frame(32767, -32767), pick_gap());
        send_frame(mk_frame(16384, 16384), pick_gap());
        send_frame(mk_frame(32767, 32767), pick_gap());
        send_frame(mk_frame(32767, 32767), pick_gap());
        send_frame(mk_frame(-32768, 100), pick_gap());
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: configure(0, 0, 0, 0, 0, 0);
                1: configure('1, '1, '1, '1, '1, '1);
                2: configure(65536, 65536, 65535, 65535, 65535, 65536000);
                default: begin
                    logic [CFG_DW-1:0] mk;
                    case ($urandom_range(0, 9))
                        0, 1: mk = $urandom_range(0, 65536000);
                        2:    mk = $urandom();
                        default: mk = $urandom_range(0, 4*65536);
                    endcase
                    configure(rand_level(), rand_level(), rand_coef(), rand_coef(),
                              rand_coef(), mk);
                end
            endcase
            repeat (PHASE_FRAMES) send_frame(next_frame(), pick_gap());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_frames.size() != 0)
            sb.report("frames never returned", 0, sb.expected_frames.size());

        $display("checked %0d frames under %0d register settings plus reset defaults",
                 sb.frames_checked, settings_cnt);
        $display("%0d frames hit a zero attack envelope, %0d output samples clipped",
                 sb.zero_env_hits, sb.clipped_samples);
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", sb.failures);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
